[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Antecedent true implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent true implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/rsfd_pkg.sv]
// Types and constants of the range sensor fusion distance unit.
package rsfd_pkg;

   localparam int READING_BITS = 10;
   localparam int SONAR_W      = 16;
   localparam int CFG_W        = 10;
   localparam int GROUP_W      = 2;
   localparam int DIST_W       = 20;
   localparam int SRC_W        = 2;
   localparam int CSR_IDX_W    = 2;

   // sonar * 100 needs 7 extra bits
   localparam int SCALE_W = 7;
   localparam int NUM_W   = SONAR_W + SCALE_W;
   // 9996 needs 14 bits
   localparam int DEN_W   = (READING_BITS > 14) ? READING_BITS : 14;
   localparam int CMP_W   = (READING_BITS > CFG_W) ? READING_BITS : CFG_W;

   localparam logic [NUM_W-1:0]  SR_NUMER    = NUM_W'(200000);
   localparam logic [NUM_W-1:0]  LR_NUMER    = NUM_W'(934950);
   localparam logic [NUM_W-1:0]  SONAR_SCALE = NUM_W'(100);
   localparam logic [DEN_W-1:0]  SONAR_CPI   = DEN_W'(9996);
   localparam logic [DIST_W-1:0] DIST_MAX    = '1;

   localparam logic [CFG_W-1:0] THRESHOLD_RESET = CFG_W'(300);
   localparam logic [CFG_W-1:0] FLOOR_RESET     = CFG_W'(100);

   localparam logic [CSR_IDX_W-1:0] REG_SHORT_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_LONG_FLOOR      = CSR_IDX_W'(1);

   typedef enum logic [GROUP_W-1:0] {
      GRP_TURRET = 2'd0,
      GRP_FRONT  = 2'd1,
      GRP_REAR   = 2'd2,
      GRP_NONE   = 2'd3
   } grp_type;

   typedef enum logic [SRC_W-1:0] {
      SRC_SHORT = 2'd0,
      SRC_LONG  = 2'd1,
      SRC_SONAR = 2'd2,
      SRC_NONE  = 2'd3
   } src_type;

   typedef struct packed {
      logic [CFG_W-1:0] threshold;
      logic [CFG_W-1:0] floor;
   } cfg_type;

   typedef struct packed {
      logic [GROUP_W-1:0]      sensor_group;
      logic [READING_BITS-1:0] long_range_reading;
      logic [READING_BITS-1:0] short_range_reading;
      logic [SONAR_W-1:0]      sonar_count;
   } req_type;

   // one divider stage: numerator bits shift out at the top, quotient bits in at the bottom
   typedef struct packed {
      logic              valid;
      logic [NUM_W-1:0]  numq;
      logic [DEN_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
      logic              sat;
      src_type           src;
   } stage_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      src_type           src;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic out_valid;
   } buf_status_type;

endpackage

[rtl/core/rsfd_if.sv]
// Channel interfaces: request, response and register write.
interface rsfd_req_if import rsfd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [GROUP_W-1:0]      sensor_group;
   logic [READING_BITS-1:0] long_range_reading;
   logic [READING_BITS-1:0] short_range_reading;
   logic [SONAR_W-1:0]      sonar_count;

   modport source (output valid, sensor_group, long_range_reading, short_range_reading,
                   sonar_count, input ready);
   modport sink (input valid, sensor_group, long_range_reading, short_range_reading,
                 sonar_count, output ready);
endinterface

interface rsfd_rsp_if import rsfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance_hundredths;
   logic [SRC_W-1:0]  source_used;

   modport source (output valid, distance_hundredths, source_used, input ready);
   modport sink (input valid, distance_hundredths, source_used, output ready);
endinterface

interface rsfd_csr_if import rsfd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [CFG_W-1:0]     wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

[rtl/core/rsfd_select.sv]
// Source selection and divider operand setup, one registered stage.
module rsfd_select import rsfd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  req_type   req,
   input  cfg_type   cfg,
   output stage_type stage_out
);

   stage_type         stage_ff;
   stage_type         stage_in;
   logic [NUM_W-1:0]  sonar_prod;
   logic [CMP_W-1:0]  sr_ext;
   logic [CMP_W-1:0]  lr_ext;
   logic [CMP_W-1:0]  thr_ext;
   logic [CMP_W-1:0]  floor_ext;
   logic [DEN_W-1:0]  sr_den;
   logic [DEN_W-1:0]  lr_den;

   assign sonar_prod = NUM_W'(req.sonar_count) * SONAR_SCALE;
   assign sr_ext     = CMP_W'(req.short_range_reading);
   assign lr_ext     = CMP_W'(req.long_range_reading);
   assign thr_ext    = CMP_W'(cfg.threshold);
   assign floor_ext  = CMP_W'(cfg.floor);
   assign sr_den     = DEN_W'(req.short_range_reading);
   assign lr_den     = DEN_W'(req.long_range_reading);

   always_comb begin
      stage_in.valid = in_valid;
      stage_in.rem   = '0;
      stage_in.numq  = '0;
      stage_in.den   = DEN_W'(1);
      stage_in.sat   = 1'b0;
      stage_in.src   = SRC_NONE;
      unique case (grp_type'(req.sensor_group))
         GRP_TURRET, GRP_FRONT: begin
            if (sr_ext >= thr_ext) begin
               stage_in.numq = SR_NUMER;
               stage_in.den  = sr_den;
               stage_in.sat  = (sr_den == '0);
               stage_in.src  = SRC_SHORT;
            end else if (lr_ext < floor_ext) begin
               stage_in.numq = sonar_prod;
               stage_in.den  = SONAR_CPI;
               stage_in.src  = SRC_SONAR;
            end else begin
               stage_in.numq = LR_NUMER;
               stage_in.den  = lr_den;
               stage_in.sat  = (lr_den == '0);
               stage_in.src  = SRC_LONG;
            end
         end
         GRP_REAR: begin
            // lr > floor rules out a zero divisor
            if (lr_ext > floor_ext) begin
               stage_in.numq = LR_NUMER;
               stage_in.den  = lr_den;
               stage_in.src  = SRC_LONG;
            end else begin
               stage_in.numq = sonar_prod;
               stage_in.den  = SONAR_CPI;
               stage_in.src  = SRC_SONAR;
            end
         end
         GRP_NONE: begin
            stage_in.src = SRC_NONE;
         end
         default: begin
            stage_in.src = SRC_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

[rtl/core/rsfd_div_cell.sv]
// One restoring divider cell: settles one quotient bit per item.
module rsfd_div_cell import rsfd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  stage_type stage_prev,
   output stage_type stage_next
);

   stage_type          stage_ff;
   stage_type          stage_in;
   logic [DEN_W:0]     trial;
   logic [DEN_W:0]     den_ext;
   logic [DEN_W:0]     diff;
   logic               fits;

   assign trial   = {stage_prev.rem, stage_prev.numq[NUM_W-1]};
   assign den_ext = {1'b0, stage_prev.den};
   assign fits    = (trial >= den_ext);
   assign diff    = trial - den_ext;

   always_comb begin
      stage_in      = stage_prev;
      stage_in.numq = {stage_prev.numq[NUM_W-2:0], fits};
      stage_in.rem  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_next = stage_ff;

endmodule

[rtl/core/rsfd_out_buf.sv]
// Output register with skid entry.
module rsfd_out_buf import rsfd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  rsp_type        push_data,
   input  logic           out_ready,
   output rsp_type        out_data,
   output buf_status_type status
);

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    pop;

   assign pop = main_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
            main_ff       <= push_data;
         end
      end else if (!main_valid_ff) begin
         main_valid_ff <= push;
         main_ff       <= push_data;
      end else if (push) begin
         skid_ff       <= push_data;
         skid_valid_ff <= 1'b1;
      end
   end

   assign out_data         = main_ff;
   assign status.full      = skid_valid_ff;
   assign status.out_valid = main_valid_ff;

endmodule

[rtl/core/range_sensor_fusion_distance_unit.sv]
// Top level of the range sensor fusion distance unit.
//
// Usage:
//   req_chan  - one transfer per query: sensor group, long-range IR, short-range IR
//               and sonar echo count.
//   rsp_chan  - one transfer per query, in order: distance in hundredths of an inch
//               and the source that produced it.
//   csr_chan  - register writes (index 0 short-range threshold, index 1 long-range
//               floor); always ready, other indexes are dropped. Write only when idle.
// Pipeline: the request transfer loads the select stage, then 23 divider cells, one per
// numerator bit, then the output register.
// Throughput: one query per cycle while the skid entry is empty; the divider is a chain
// of cells that each settle one quotient bit and hand the partial remainder on as the chain advances.
// Stall: the output has a skid entry; when it fills, the whole chain holds and
// req_chan.ready drops. req_chan.ready is a register output, never rsp_chan.ready.
// Reset: synchronous, clears all valid bits, threshold back to 300, floor to 100.
module range_sensor_fusion_distance_unit import rsfd_pkg::*; (
   input logic         clock,
   input logic         reset,
   rsfd_req_if.sink    req_chan,
   rsfd_rsp_if.source  rsp_chan,
   rsfd_csr_if.sink    csr_chan
);

`include "assert_macros.svh"

   logic [CFG_W-1:0] threshold_ff;
   logic [CFG_W-1:0] floor_ff;
   cfg_type          cfg;
   req_type          req;
   stage_type        chain [NUM_W+1];
   buf_status_type   buf_status;
   rsp_type          last_rsp;
   rsp_type          out_data;
   logic             advance;
   logic             push;
   logic             quot_big;

   // register file; a write is stored at the edge that transfers it
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         floor_ff     <= FLOOR_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.reg_index == REG_SHORT_THRESHOLD) begin
            threshold_ff <= csr_chan.wdata;
         end else if (csr_chan.reg_index == REG_LONG_FLOOR) begin
            floor_ff <= csr_chan.wdata;
         end
      end
   end

   assign cfg.threshold = threshold_ff;
   assign cfg.floor     = floor_ff;

   // chain moves as a whole unless the skid entry is occupied
   assign advance        = !buf_status.full;
   assign req_chan.ready = advance;

   assign req.sensor_group        = req_chan.sensor_group;
   assign req.long_range_reading  = req_chan.long_range_reading;
   assign req.short_range_reading = req_chan.short_range_reading;
   assign req.sonar_count         = req_chan.sonar_count;

   rsfd_select u_select (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_chan.valid),
      .req       (req),
      .cfg       (cfg),
      .stage_out (chain[0])
   );

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      rsfd_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .stage_prev (chain[i]),
         .stage_next (chain[i+1])
      );
   end

   // zero divisor, or a quotient past the field, clamps to full scale
   assign quot_big = |chain[NUM_W].numq[NUM_W-1:DIST_W];

   always_comb begin
      last_rsp.src = chain[NUM_W].src;
      if (chain[NUM_W].sat || quot_big) begin
         last_rsp.distance = DIST_MAX;
      end else begin
         last_rsp.distance = chain[NUM_W].numq[DIST_W-1:0];
      end
   end

   assign push = advance && chain[NUM_W].valid;

   rsfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (last_rsp),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data),
      .status    (buf_status)
   );

   assign rsp_chan.valid               = buf_status.out_valid;
   assign rsp_chan.distance_hundredths = out_data.distance;
   assign rsp_chan.source_used         = out_data.src;

   // skid entry only fills behind a waiting output
   `ASSERT_IMPLIES(a_skid_behind_main, clock, reset, buf_status.full, rsp_chan.valid, "skid without output")
   // input back-pressure only while a response is pending
   `ASSERT_IMPLIES(a_ready_low_pending, clock, reset, !req_chan.ready, rsp_chan.valid, "stall without response")
   // no-source responses carry zero distance
   `ASSERT_IMPLIES(a_none_zero, clock, reset, rsp_chan.valid && (rsp_chan.source_used == SRC_NONE), rsp_chan.distance_hundredths == '0, "none source nonzero")
   // a held response that is not taken stays valid
   `ASSERT_NEXT(a_full_holds, clock, reset, buf_status.full && !rsp_chan.ready, rsp_chan.valid && buf_status.full, "skid lost")

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the range sensor fusion distance unit.
module tb_top import rsfd_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // Conversion constants, hundredths of an inch
   localparam int unsigned SHORT_NUMERATOR = 200000;
   localparam int unsigned LONG_NUMERATOR  = 934950;
   localparam int unsigned SONAR_PER_INCH  = 9996;
   localparam int unsigned SONAR_HUNDREDTH = 100;
   localparam logic [DIST_W-1:0] DIST_SATURATED = '1;
   localparam logic [CFG_W-1:0]  READING_TOP    = '1;

   // Register index the block must drop
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = CSR_IDX_W'(2);

   // Timing: the pipeline is 25 deep, so these leave plenty of margin
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int ITEMS_PER_PHASE = 62;
   localparam int PHASE_COUNT     = 8;

   logic clock = 1'b0;
   logic reset;

   rsfd_req_if req_bus ();
   rsfd_rsp_if rsp_bus ();
   rsfd_csr_if csr_bus ();

   range_sensor_fusion_distance_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Register copies seen by the distance predictor
   logic [CFG_W-1:0] model_threshold;
   logic [CFG_W-1:0] model_floor;

   // Distances still owed by the block, oldest first
   rsp_type pending_distances [$];
   int      failures = 0;

   // Idling knobs, percent of cycles
   int sender_gap_pct    = 0;
   int receiver_stall_pct = 0;
   logic hold_go = 1'b0;

   // ------------------------------------------------------------------
   // Distance predictor
   // ------------------------------------------------------------------
   function automatic logic [DIST_W-1:0] quotient_sat(int unsigned numer, int unsigned denom);
      if (denom == 0)
         return DIST_SATURATED;
      return DIST_W'(numer / denom);
   endfunction

   function automatic rsp_type predict_distance(req_type q, logic [CFG_W-1:0] threshold,
                                                logic [CFG_W-1:0] floor_lvl);
      int unsigned long_rd;
      int unsigned short_rd;
      int unsigned sonar_dist;
      rsp_type     r;
      long_rd    = q.long_range_reading;
      short_rd   = q.short_range_reading;
      sonar_dist = (int'(q.sonar_count) * SONAR_HUNDREDTH) / SONAR_PER_INCH;
      r.distance = '0;
      r.src      = SRC_NONE;
      case (grp_type'(q.sensor_group))
         GRP_TURRET, GRP_FRONT: begin
            // short range wins when trusted, sonar only below the floor
            if (short_rd >= threshold) begin
               r.distance = quotient_sat(SHORT_NUMERATOR, short_rd);
               r.src      = SRC_SHORT;
            end else if (long_rd < floor_lvl) begin
               r.distance = DIST_W'(sonar_dist);
               r.src      = SRC_SONAR;
            end else begin
               r.distance = quotient_sat(LONG_NUMERATOR, long_rd);
               r.src      = SRC_LONG;
            end
         end
         GRP_REAR: begin
            // rear has no short-range sensor; floor itself goes to sonar
            if (long_rd > floor_lvl) begin
               r.distance = quotient_sat(LONG_NUMERATOR, long_rd);
               r.src      = SRC_LONG;
            end else begin
               r.distance = DIST_W'(sonar_dist);
               r.src      = SRC_SONAR;
            end
         end
         default: begin
            r.distance = '0;
            r.src      = SRC_NONE;
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Directed stimulus: register setting per row, literal result where
   // it is obvious (group none, zero divisors)
   // ------------------------------------------------------------------
   typedef struct packed {
      logic [CFG_W-1:0]        threshold;
      logic [CFG_W-1:0]        floor_lvl;
      grp_type                 grp;
      logic [READING_BITS-1:0] long_rd;
      logic [READING_BITS-1:0] short_rd;
      logic [SONAR_W-1:0]      sonar;
      logic                    literal;
      logic [DIST_W-1:0]       distance;
      src_type                 src;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 22;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // after reset: group none gives zero
      '{10'd300,  10'd100,  GRP_NONE,   10'd1023, 10'd1023, 16'hFFFF, 1'b1, 20'd0, SRC_NONE},
      '{10'd300,  10'd100,  GRP_TURRET, 10'd0,    10'd299,  16'hFFFF, 1'b0, 20'd0, SRC_NONE},
      '{10'd300,  10'd100,  GRP_TURRET, 10'd100,  10'd299,  16'h0000, 1'b0, 20'd0, SRC_NONE},
      '{10'd300,  10'd100,  GRP_FRONT,  10'd99,   10'd300,  16'd1234, 1'b0, 20'd0, SRC_NONE},
      '{10'd300,  10'd100,  GRP_FRONT,  10'd1023, 10'd1023, 16'h0000, 1'b0, 20'd0, SRC_NONE},
      '{10'd300,  10'd100,  GRP_FRONT,  10'd1023, 10'd0,    16'hFFFF, 1'b0, 20'd0, SRC_NONE},
      '{10'd300,  10'd100,  GRP_REAR,   10'd100,  10'd1023, 16'd5000, 1'b0, 20'd0, SRC_NONE},
      '{10'd300,  10'd100,  GRP_REAR,   10'd101,  10'd0,    16'd5000, 1'b0, 20'd0, SRC_NONE},
      '{10'd300,  10'd100,  GRP_REAR,   10'd1023, 10'd1023, 16'hFFFF, 1'b0, 20'd0, SRC_NONE},
      '{10'd300,  10'd100,  GRP_REAR,   10'd0,    10'd0,    16'h0000, 1'b0, 20'd0, SRC_NONE},
      '{10'd300,  10'd100,  GRP_TURRET, 10'd512,  10'd341,  16'hAAAA, 1'b0, 20'd0, SRC_NONE},
      // threshold zero: zero short-range reading saturates
      '{10'd0,    10'd0,    GRP_TURRET, 10'd0,    10'd0,    16'd9996, 1'b1, 20'hFFFFF, SRC_SHORT},
      '{10'd0,    10'd0,    GRP_FRONT,  10'd1023, 10'd0,    16'h0000, 1'b1, 20'hFFFFF, SRC_SHORT},
      // floor zero: zero long-range reading saturates on turret/front unless short range wins
      '{10'd1023, 10'd0,    GRP_TURRET, 10'd0,    10'd1022, 16'hFFFF, 1'b1, 20'hFFFFF, SRC_LONG},
      '{10'd1023, 10'd0,    GRP_FRONT,  10'd0,    10'd1023, 16'h0000, 1'b0, 20'd0, SRC_NONE},
      '{10'd1023, 10'd0,    GRP_REAR,   10'd0,    10'd0,    16'hFFFF, 1'b0, 20'd0, SRC_NONE},
      '{10'd1023, 10'd1023, GRP_TURRET, 10'd1022, 10'd1022, 16'hFFFF, 1'b0, 20'd0, SRC_NONE},
      '{10'd1023, 10'd1023, GRP_FRONT,  10'd1023, 10'd1022, 16'h0000, 1'b0, 20'd0, SRC_NONE},
      '{10'd1023, 10'd1023, GRP_REAR,   10'd1023, 10'd0,    16'd9995, 1'b0, 20'd0, SRC_NONE},
      '{10'd1023, 10'd1023, GRP_NONE,   10'd0,    10'd0,    16'h0000, 1'b1, 20'd0, SRC_NONE},
      '{10'd0,    10'd1023, GRP_TURRET, 10'd1,    10'd0,    16'd100,  1'b1, 20'hFFFFF, SRC_SHORT},
      '{10'd0,    10'd1023, GRP_REAR,   10'd0,    10'd1,    16'd1,    1'b0, 20'd0, SRC_NONE}
   };

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------
   // Present one query, hold it until the transfer, then book its distance.
   // valid stays high into the next query unless an idle gap is drawn.
   task automatic send_query(req_type q, rsp_type want);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_gap_pct)
         gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid               <= 1'b1;
      req_bus.sensor_group        <= q.sensor_group;
      req_bus.long_range_reading  <= q.long_range_reading;
      req_bus.short_range_reading <= q.short_range_reading;
      req_bus.sonar_count         <= q.sonar_count;
      do @(posedge clock); while (!req_bus.ready);
      pending_distances.push_back(want);
   endtask

   // Drop valid and wait for every booked distance, then stay quiet before returning.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (pending_distances.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One write, then the register channel goes idle
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata     <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == REG_SHORT_THRESHOLD)
         model_threshold = data;
      else if (idx == REG_LONG_FLOOR)
         model_floor = data;
      @(posedge clock);
   endtask

   // Reading biased toward the edges and toward the register it is compared with
   function automatic logic [READING_BITS-1:0] pick_reading(logic [CFG_W-1:0] pivot);
      int v;
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = READING_TOP;
         2, 3: v = int'(pivot) + int'($urandom_range(0, 4)) - 2;
         default: v = $urandom_range(0, READING_TOP);
      endcase
      if (v < 0)
         v = 0;
      if (v > READING_TOP)
         v = READING_TOP;
      return READING_BITS'(v);
   endfunction

   function automatic req_type random_query();
      req_type q;
      q.sensor_group        = ($urandom_range(0, 9) == 0) ? GRP_NONE
                              : GROUP_W'($urandom_range(0, 2));
      q.long_range_reading  = pick_reading(model_floor);
      q.short_range_reading = pick_reading(model_threshold);
      case ($urandom_range(0, 5))
         0: q.sonar_count = '0;
         1: q.sonar_count = '1;
         default: q.sonar_count = SONAR_W'($urandom_range(0, 65535));
      endcase
      return q;
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      req_type q;
      rsp_type want;
      logic [CFG_W-1:0] next_thr;
      logic [CFG_W-1:0] next_flr;

      reset                       <= 1'b1;
      req_bus.valid               <= 1'b0;
      req_bus.sensor_group        <= '0;
      req_bus.long_range_reading  <= '0;
      req_bus.short_range_reading <= '0;
      req_bus.sonar_count         <= '0;
      csr_bus.valid               <= 1'b0;
      csr_bus.reg_index           <= '0;
      csr_bus.wdata               <= '0;
      model_threshold = THRESHOLD_RESET;
      model_floor     = FLOOR_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; registers change only with the block drained
      foreach (directed_rows[i]) begin
         if (directed_rows[i].threshold != model_threshold
             || directed_rows[i].floor_lvl != model_floor) begin
            wait_for_drain();
            write_register(REG_SHORT_THRESHOLD, directed_rows[i].threshold);
            write_register(REG_LONG_FLOOR, directed_rows[i].floor_lvl);
         end
         q.sensor_group        = directed_rows[i].grp;
         q.long_range_reading  = directed_rows[i].long_rd;
         q.short_range_reading = directed_rows[i].short_rd;
         q.sonar_count         = directed_rows[i].sonar;
         if (directed_rows[i].literal) begin
            want.distance = directed_rows[i].distance;
            want.src      = directed_rows[i].src;
         end else begin
            want = predict_distance(q, model_threshold, model_floor);
         end
         send_query(q, want);
      end

      // Random phases: a register setting and an idling mode each
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_for_drain();
         case (phase)
            0: begin next_thr = THRESHOLD_RESET; next_flr = FLOOR_RESET; end
            1: begin next_thr = '0;              next_flr = '0;          end
            2: begin next_thr = READING_TOP;     next_flr = READING_TOP; end
            4: begin next_thr = READING_TOP;     next_flr = '0;          end
            5: begin next_thr = '0;              next_flr = READING_TOP; end
            default: begin
               next_thr = CFG_W'($urandom_range(0, READING_TOP));
               next_flr = CFG_W'($urandom_range(0, READING_TOP));
            end
         endcase
         write_register(REG_SHORT_THRESHOLD, next_thr);
         write_register(REG_LONG_FLOOR, next_flr);
         // a write to an unused index must leave both registers alone
         if (phase == 3)
            write_register(REG_UNUSED, CFG_W'($urandom_range(0, READING_TOP)));

         case (phase % 4)
            0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_gap_pct = 78; receiver_stall_pct = 0;  end
            2: begin sender_gap_pct = 0;  receiver_stall_pct = 78; end
            default: begin sender_gap_pct = 25; receiver_stall_pct = 25; end
         endcase

         // Back-pressure: receiver holds off while queries keep coming,
         // so the pipeline fills and req ready drops
         if (phase == 0) begin
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            q    = random_query();
            want = predict_distance(q, model_threshold, model_floor);
            send_query(q, want);
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_distances.size() != 0) begin
         $display("%0t: %0d distances never arrived", $time, pending_distances.size());
         failures++;
      end
      if (failures == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go)
            hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Result check: every response transfer against the oldest booking
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_distances.size() == 0) begin
            $display("%0t: unexpected distance %0d source %0d", $time,
                     rsp_bus.distance_hundredths, rsp_bus.source_used);
            failures++;
         end else begin
            want = pending_distances.pop_front();
            if (rsp_bus.distance_hundredths !== want.distance) begin
               $display("%0t: distance expected %0d got %0d", $time,
                        want.distance, rsp_bus.distance_hundredths);
               failures++;
            end
            if (rsp_bus.source_used !== want.src) begin
               $display("%0t: source expected %0d got %0d", $time,
                        want.src, rsp_bus.source_used);
               failures++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long without any transfer on any channel
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

endmodule

[range_sensor_fusion_distance_unit.f]
+incdir+rtl/core
rtl/core/rsfd_pkg.sv
rtl/core/rsfd_if.sv
rtl/core/rsfd_select.sv
rtl/core/rsfd_div_cell.sv
rtl/core/rsfd_out_buf.sv
rtl/core/range_sensor_fusion_distance_unit.sv
tb/tb_top.sv
